FILE: design/mkh_pkg.sv
package mkh_pkg;

    // hash constants
    localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned MUR_R = 47;

    // default size limit handed to the top level
    localparam int unsigned MAX_KEY_BYTES_DEF = 4096;

    // configuration register indexes
    localparam logic CFG_SEED      = 1'b0;
    localparam logic CFG_KEY_BYTES = 1'b1;

    // configuration reset values
    localparam logic [31:0] SEED_RST      = 32'd0;
    localparam logic [12:0] KEY_BYTES_RST = 13'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_NEXT
    } state_t;

    // which multiply (or dispatch step) is in flight
    typedef enum logic [2:0] {
        J_LEN,
        J_WORD,
        J_K1,
        J_K2,
        J_H,
        J_FIN
    } job_t;

    // partial product phases of one 64-bit multiply by MUR_M
    typedef enum logic [1:0] {
        PH0,
        PH1,
        PH2
    } phase_t;

    // multiplier operand sources
    typedef enum logic [2:0] {
        OP_LEN,
        OP_KEY,
        OP_KXS,
        OP_HXK,
        OP_TAIL,
        OP_FIN
    } op_sel_t;

    typedef struct packed {
        logic     load_word;
        logic     op_load;
        op_sel_t  op_sel;
        logic     mul_en;
        phase_t   phase;
        logic     h_init;
        logic     h_load_acc;
        logic     word_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic full_word;
        logic last;
    } status_t;

endpackage

FILE: design/mkh_datapath.sv
module mkh_datapath #(
    parameter int unsigned MAX_KEY_BYTES = mkh_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic [63:0]      key_word,
    input  mkh_pkg::cmd_t    cmd,
    output mkh_pkg::status_t st,
    output logic [63:0]      hash
);

    localparam int unsigned MAX_WORDS = (MAX_KEY_BYTES + 7) / 8;
    localparam int unsigned WORD_W    = $clog2(MAX_WORDS + 1);

    logic [31:0]       seed_reg;
    logic [12:0]       key_bytes_reg;
    logic [WORD_W-1:0] words_reg;
    logic [63:0]       k_reg;
    logic [63:0]       h_reg;
    logic [63:0]       op_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       hash_reg;

    logic [31:0] len32;
    logic [31:0] kb32;
    logic [31:0] total_words;
    logic [31:0] full_words;
    logic [31:0] words32;
    logic [2:0]  tail;
    logic [63:0] tail_mask;
    logic [63:0] op_next;
    logic [63:0] acc_xs;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;

    // effective key length: zero reads as one, large values saturate
    always_comb
    begin
        kb32 = {19'd0, key_bytes_reg};
        if (kb32 == 32'd0)
        begin
            len32 = 32'd1;
        end
        else if (kb32 > 32'(MAX_KEY_BYTES))
        begin
            len32 = 32'(MAX_KEY_BYTES);
        end
        else
        begin
            len32 = kb32;
        end
    end

    assign total_words = (len32 + 32'd7) >> 3;
    assign full_words  = len32 >> 3;
    assign tail        = len32[2:0];
    assign words32     = 32'(words_reg);

    // word position status
    assign st.first     = (words_reg == '0);
    assign st.full_word = (words32 < full_words);
    assign st.last      = ((words32 + 32'd1) >= total_words);

    // keep the low tail bytes of a partial word
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail_mask[8*i +: 8] = (3'(i) < tail) ? 8'hff : 8'h00;
        end
    end

    assign acc_xs = acc_reg ^ (acc_reg >> mkh_pkg::MUR_R);

    // operand select for the next multiply
    always_comb
    begin
        case (cmd.op_sel)
            mkh_pkg::OP_LEN:  op_next = 64'(len32);
            mkh_pkg::OP_KEY:  op_next = k_reg;
            mkh_pkg::OP_KXS:  op_next = acc_xs;
            mkh_pkg::OP_HXK:  op_next = h_reg ^ acc_reg;
            mkh_pkg::OP_TAIL: op_next = h_reg ^ (k_reg & tail_mask);
            mkh_pkg::OP_FIN:  op_next = acc_xs;
            default:          op_next = k_reg;
        endcase
    end

    // shared 32x32 multiplier, one partial product per phase
    assign mul_x = (cmd.phase == mkh_pkg::PH1) ? op_reg[63:32] : op_reg[31:0];
    assign mul_y = (cmd.phase == mkh_pkg::PH2) ? mkh_pkg::MUR_M[63:32]
                                               : mkh_pkg::MUR_M[31:0];
    assign prod  = mul_x * mul_y;

    // configuration registers and word counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= mkh_pkg::SEED_RST;
            key_bytes_reg <= mkh_pkg::KEY_BYTES_RST;
            words_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mkh_pkg::CFG_SEED:      seed_reg      <= cfg_data;
                    mkh_pkg::CFG_KEY_BYTES: key_bytes_reg <= cfg_data[12:0];
                    default:                seed_reg      <= seed_reg;
                endcase
                words_reg <= '0;
            end
            else if (cmd.word_step)
            begin
                words_reg <= st.last ? '0 : words_reg + WORD_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            k_reg <= key_word;
        end
        if (cmd.op_load)
        begin
            op_reg <= op_next;
        end
        if (cmd.mul_en)
        begin
            if (cmd.phase == mkh_pkg::PH0)
            begin
                acc_reg <= prod;
            end
            else
            begin
                acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
            end
        end
        if (cmd.h_init)
        begin
            h_reg <= {32'd0, seed_reg} ^ acc_reg;
        end
        else if (cmd.h_load_acc)
        begin
            h_reg <= acc_reg;
        end
        if (cmd.out_load)
        begin
            hash_reg <= acc_xs;
        end
    end

    assign hash = hash_reg;

endmodule

FILE: design/mkh_ctrl.sv
module mkh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mkh_pkg::status_t st,
    output mkh_pkg::cmd_t    cmd
);

    mkh_pkg::state_t state_reg;
    mkh_pkg::state_t state_next;
    mkh_pkg::job_t   job_reg;
    mkh_pkg::job_t   job_next;
    mkh_pkg::phase_t phase_reg;
    mkh_pkg::phase_t phase_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mkh_pkg::S_IDLE;
            job_reg       <= mkh_pkg::J_LEN;
            phase_reg     <= mkh_pkg::PH0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.phase  = phase_reg;

        case (state_reg)
            mkh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_word = 1'b1;
                    if (st.first)
                    begin
                        cmd.op_load = 1'b1;
                        cmd.op_sel  = mkh_pkg::OP_LEN;
                        job_next    = mkh_pkg::J_LEN;
                        phase_next  = mkh_pkg::PH0;
                        state_next  = mkh_pkg::S_MUL;
                    end
                    else
                    begin
                        job_next   = mkh_pkg::J_WORD;
                        state_next = mkh_pkg::S_NEXT;
                    end
                end
            end

            mkh_pkg::S_MUL:
            begin
                cmd.mul_en = 1'b1;
                case (phase_reg)
                    mkh_pkg::PH0: phase_next = mkh_pkg::PH1;
                    mkh_pkg::PH1: phase_next = mkh_pkg::PH2;
                    default:
                    begin
                        phase_next = mkh_pkg::PH0;
                        state_next = mkh_pkg::S_NEXT;
                    end
                endcase
            end

            mkh_pkg::S_NEXT:
            begin
                case (job_reg)
                    mkh_pkg::J_LEN:
                    begin
                        cmd.h_init = 1'b1;
                        job_next   = mkh_pkg::J_WORD;
                    end
                    mkh_pkg::J_WORD:
                    begin
                        cmd.op_load = 1'b1;
                        if (st.full_word)
                        begin
                            cmd.op_sel = mkh_pkg::OP_KEY;
                            job_next   = mkh_pkg::J_K1;
                        end
                        else
                        begin
                            cmd.op_sel = mkh_pkg::OP_TAIL;
                            job_next   = mkh_pkg::J_H;
                        end
                        phase_next = mkh_pkg::PH0;
                        state_next = mkh_pkg::S_MUL;
                    end
                    mkh_pkg::J_K1:
                    begin
                        cmd.op_load = 1'b1;
                        cmd.op_sel  = mkh_pkg::OP_KXS;
                        job_next    = mkh_pkg::J_K2;
                        phase_next  = mkh_pkg::PH0;
                        state_next  = mkh_pkg::S_MUL;
                    end
                    mkh_pkg::J_K2:
                    begin
                        cmd.op_load = 1'b1;
                        cmd.op_sel  = mkh_pkg::OP_HXK;
                        job_next    = mkh_pkg::J_H;
                        phase_next  = mkh_pkg::PH0;
                        state_next  = mkh_pkg::S_MUL;
                    end
                    mkh_pkg::J_H:
                    begin
                        cmd.h_load_acc = 1'b1;
                        cmd.word_step  = 1'b1;
                        if (st.last)
                        begin
                            cmd.op_load = 1'b1;
                            cmd.op_sel  = mkh_pkg::OP_FIN;
                            job_next    = mkh_pkg::J_FIN;
                            phase_next  = mkh_pkg::PH0;
                            state_next  = mkh_pkg::S_MUL;
                        end
                        else
                        begin
                            state_next = mkh_pkg::S_IDLE;
                        end
                    end
                    mkh_pkg::J_FIN:
                    begin
                        // wait for the output slot to free up
                        if (!out_valid_reg || out_ready)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = mkh_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = mkh_pkg::S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = mkh_pkg::S_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // multiply phases run in order
    a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mkh_pkg::S_MUL && phase_reg == mkh_pkg::PH0)
        |=> (state_reg == mkh_pkg::S_MUL && phase_reg == mkh_pkg::PH1))
        else $error("multiply phase sequence broken");

    // a result never overwrites one still waiting
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    // an accepted beat always starts work
    a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready)
        |=> (state_reg == mkh_pkg::S_MUL || state_reg == mkh_pkg::S_NEXT))
        else $error("accepted beat did not start work");

    // finalize only follows the last hash multiply
    a_fin_after_h: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mkh_pkg::S_MUL && job_reg == mkh_pkg::J_FIN
         && phase_reg == mkh_pkg::PH0)
        |-> $past(job_reg) == mkh_pkg::J_H)
        else $error("finalize entered without hash multiply");

endmodule

FILE: design/murmur64a_key_hash_unit.sv
// channel   direction  payload                       handshake
// s_axis    in         tdata[63:0] = key_word        tvalid / tready
// m_axis    out        tdata[63:0] = hash            tvalid / tready
// cfg       in         cfg_index 0 seed, 1 key_bytes cfg_we, no wait
//
// every 64-bit multiply by the hash constant runs in partial-product phases on one
// shared 32x32 multiplier; a full word costs 3 multiplies plus dispatch, a tail
// word one multiply; the first word of a key adds a multiply for the length
// product, the last word adds one for finalize
// reset clears the controller, the word count and the configuration registers
// a new beat is taken while a finished hash still waits on m_axis;
// finalize stalls only while that earlier hash is still untaken
module murmur64a_key_hash_unit #(
    parameter int unsigned MAX_KEY_BYTES = mkh_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] key_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] hash
);

    mkh_pkg::cmd_t    cmd;
    mkh_pkg::status_t st;

    mkh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    mkh_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_word  (s_axis_tdata),
        .cmd       (cmd),
        .st        (st),
        .hash      (m_axis_tdata)
    );

endmodule

FILE: dv/murmur64a_key_hash_unit_tb.sv
`timescale 1ns / 1ps

module murmur64a_key_hash_unit_tb;

    localparam int unsigned MAX_BYTES    = mkh_pkg::MAX_KEY_BYTES_DEF;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          STALL_LIMIT  = 2000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = mkh_pkg::CFG_SEED;
    logic [31:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    // local copy of the hasher state and configuration
    logic [31:0] model_seed;
    logic [12:0] model_key_bytes;
    logic [63:0] model_hash;
    int          model_words;

    logic [63:0] expected_hashes[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int words_sent     = 0;
    int hashes_checked = 0;
    int cfg_writes     = 0;
    int idle_cycles    = 0;

    murmur64a_key_hash_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // product modulo 2^64 with the hash constant
    function automatic logic [63:0] times_m(input logic [63:0] x);
        return x * mkh_pkg::MUR_M;
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] h);
        logic [63:0] x;
        x = h ^ (h >> mkh_pkg::MUR_R);
        x = times_m(x);
        return x ^ (x >> mkh_pkg::MUR_R);
    endfunction

    // zero length counts as one byte, oversize saturates
    function automatic int unsigned hashed_length();
        int unsigned len;
        len = 32'(model_key_bytes);
        if (len == 0)
            len = 1;
        if (len > MAX_BYTES)
            len = MAX_BYTES;
        return len;
    endfunction

    function automatic int unsigned words_per_key();
        return (hashed_length() + 7) / 8;
    endfunction

    function automatic void rearm_model();
        logic [63:0] len64;
        len64       = 64'(hashed_length());
        model_hash  = {32'd0, model_seed} ^ times_m(len64);
        model_words = 0;
    endfunction

    // fold one accepted key word into the running hash
    function automatic void absorb_key_word(input logic [63:0] w);
        int unsigned len;
        int unsigned tail;
        logic [63:0] k;
        logic [63:0] mask;
        len  = hashed_length();
        tail = len % 8;
        if (model_words < int'(len / 8))
        begin
            k          = times_m(w);
            k          = k ^ (k >> mkh_pkg::MUR_R);
            k          = times_m(k);
            model_hash = times_m(model_hash ^ k);
        end
        else
        begin
            mask       = (64'd1 << (8 * tail)) - 64'd1;
            model_hash = times_m(model_hash ^ (w & mask));
        end
        model_words++;
        if (model_words >= int'(words_per_key()))
        begin
            expected_hashes.push_back(avalanche(model_hash));
            rearm_model();
        end
    endfunction

    // receiver backpressure
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash beat, expected none, got %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_hashes.pop_front();
                hashes_checked++;
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: hash mismatch, expected %h, got %h",
                             $time, want, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one register write, then the enable is dropped before the task returns
    task automatic write_cfg(input logic idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == mkh_pkg::CFG_SEED)
            model_seed = value;
        else
            model_key_bytes = value[12:0];
        rearm_model();
        cfg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // send one key word; returns at a falling edge with tvalid still high
    task automatic send_key_word(input logic [63:0] w);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_key_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_words(input int n);
        repeat (n)
            send_key_word({$urandom, $urandom});
    endtask

    // drop tvalid, wait for every hash, then let the block go quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_hashes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // reset defaults: seed 0, eight byte keys
    task automatic test_reset_defaults();
        settle_block();
        send_key_word(64'd0);
        send_key_word({64{1'b1}});
        send_key_word(64'h0123_4567_89ab_cdef);
    endtask

    // tail sizes, zero length, unused tail bytes, seed extremes
    task automatic test_lengths_and_tails();
        settle_block();
        write_cfg(mkh_pkg::CFG_SEED, 32'hffff_ffff);
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'd1);
        send_key_word({64{1'b1}});
        send_key_word(64'h0000_0000_0000_00ff);
        settle_block();
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'd7);
        send_key_word(64'h5a5a_5a5a_5a5a_5a5a);
        settle_block();
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'd0);
        send_key_word(64'hdead_beef_cafe_f00d);
        settle_block();
        write_cfg(mkh_pkg::CFG_SEED, 32'd0);
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'd9);
        send_key_word({64{1'b1}});
        send_key_word({64{1'b1}});
        settle_block();
        write_cfg(mkh_pkg::CFG_SEED, 32'h8000_0001);
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'hfff8_0010);
        send_random_words(4);
    endtask

    // writes in the middle of a key throw the partial key away
    task automatic test_midkey_config();
        settle_block();
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'd24);
        send_random_words(1);
        settle_block();
        write_cfg(mkh_pkg::CFG_SEED, 32'h1234_5678);
        send_random_words(2);
        settle_block();
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'd13);
        send_random_words(2);
    endtask

    // largest key and a saturated length
    task automatic test_long_keys();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        settle_block();
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'd4096);
        send_random_words(words_per_key());
        settle_block();
        write_cfg(mkh_pkg::CFG_SEED, 32'hffff_ffff);
        write_cfg(mkh_pkg::CFG_KEY_BYTES, 32'hffff_ffff);
        send_random_words(words_per_key());
    endtask

    // random settings, whole keys and some abandoned ones
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_words);
        int          sent_at_start;
        int          n_keys;
        int          pick;
        logic [12:0] len;
        sent_at_start  = words_sent;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (words_sent - sent_at_start < n_words)
        begin
            settle_block();
            pick = $urandom_range(0, 2);
            if (pick != 1)
            begin
                case ($urandom_range(0, 3))
                    0:       write_cfg(mkh_pkg::CFG_SEED, 32'd0);
                    1:       write_cfg(mkh_pkg::CFG_SEED, 32'hffff_ffff);
                    default: write_cfg(mkh_pkg::CFG_SEED, $urandom);
                endcase
            end
            if (pick != 0)
            begin
                case ($urandom_range(0, 19))
                    0:       len = 13'd0;
                    1, 2:    len = 13'($urandom_range(25, 200));
                    default: len = 13'($urandom_range(1, 24));
                endcase
                write_cfg(mkh_pkg::CFG_KEY_BYTES, {19'($urandom), len});
            end
            n_keys = $urandom_range(1, 5);
            repeat (n_keys)
                send_random_words(words_per_key());
            if ($urandom_range(0, 4) == 0 && words_per_key() > 1)
                send_random_words($urandom_range(1, words_per_key() - 1));
        end
    endtask

    initial
    begin
        model_seed      = mkh_pkg::SEED_RST;
        model_key_bytes = mkh_pkg::KEY_BYTES_RST;
        rearm_model();
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_lengths_and_tails();
        test_midkey_config();
        test_long_keys();
        test_random_traffic(0, 0, 150);
        test_random_traffic(79, 0, 150);
        test_random_traffic(0, 79, 150);
        test_random_traffic(37, 37, 150);

        settle_block();
        $display("sent %0d key words over %0d config writes, checked %0d hashes",
                 words_sent, cfg_writes, hashes_checked);
        $display("lengths 0 to saturated, mid-key rewrites, idle and stall mixes");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
